>>> sv/urbfe_pkg.sv
package urbfe_pkg;

   localparam logic [7:0] CH_OPEN    = 8'h3C;
   localparam logic [7:0] CH_CLOSE   = 8'h3E;
   localparam int         FRAME_LEN  = 2;
   localparam int         NOTIFY_MIN = 3;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_LEN_ERR = 3'd2,
      ST_FMT_ERR = 3'd3,
      ST_STORED  = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_PUSH  = 1'b0,
      FUNC_PARSE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      NMODE_NOTIFY = 2'd0,
      NMODE_QUEUE  = 2'd1,
      NMODE_OFF    = 2'd2
   } nmode_type;

endpackage

>>> sv/urbfe_req_if.sv
interface urbfe_req_if import urbfe_pkg::*; ();
   logic       valid;
   logic       ready;
   func_type   func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

>>> sv/urbfe_rsp_if.sv
interface urbfe_rsp_if import urbfe_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   logic [7:0] frame_cmd;
   logic [7:0] frame_data;
   logic [6:0] fill_level;
   logic       notify;

   modport source (output valid, output status, output frame_cmd, output frame_data,
                   output fill_level, output notify, input ready);
   modport sink   (input valid, input status, input frame_cmd, input frame_data,
                   input fill_level, input notify, output ready);
endinterface

>>> sv/uart_ring_buffer_frame_extractor.sv
// Circular byte store with a '<' cmd data '>' frame parser.
//
// req_chan (valid/ready): func = push selects a store of rx_byte at the tail,
// func = parse asks for one frame to be taken from the held bytes.
// rsp_chan (valid/ready): exactly one response per request, in order.
// csr_wr_en/csr_wr_data write notify_mode; write it only while idle.
//
// A push or a parse of an empty store completes in the cycle it is taken;
// its response passes through the holding register and then the output
// register to rsp_chan. A parse scans the store through the single
// synchronous read port, one entry per cycle, with each read registered
// behind its address and checked as it returns, then finishes in S_FIN.
// Pushes sustain one per cycle when rsp_chan is not stalled.
//
// A finished response waits in a holding register while the output
// register is stalled, so one more request is taken; after that req_chan
// drops ready until rsp_chan drains.
// Reset clears the pointers, fill count and handshake state; notify_mode
// returns to "no notification". Store contents are not cleared.
module uart_ring_buffer_frame_extractor import urbfe_pkg::*; #(
   parameter int STORE_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   urbfe_req_if.sink       req_chan,
   urbfe_rsp_if.source     rsp_chan,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_wr_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FIN
   } state_type;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == AW'(STORE_DEPTH - 1)) ? '0 : AW'(p + AW'(1));
      return r;
   endfunction

   function automatic logic [CW-1:0] ptr_dist(input logic [AW-1:0] t,
                                              input logic [AW-1:0] h);
      logic [CW-1:0] r;
      if (t >= h) begin
         r = CW'(t) - CW'(h);
      end else begin
         r = CW'(t) + CW'(STORE_DEPTH) - CW'(h);
      end
      return r;
   endfunction

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] cnt_ff, cnt_in;          // cnt == STORE_DEPTH is the full mark
   nmode_type     nmode_ff, nmode_in;

   logic [CW-1:0] iss_k_ff, iss_k_in;
   logic [AW-1:0] iss_addr_ff, iss_addr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CW-1:0] rd_k_ff, rd_k_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          open_seen_ff, open_seen_in;
   logic [CW-1:0] open_off_ff, open_off_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    prev_ff, prev_in;

   logic          res_pend_ff, res_pend_in;
   status_type    res_status_ff, res_status_in;
   logic [7:0]    res_cmd_ff, res_cmd_in;
   logic [7:0]    res_data_ff, res_data_in;
   logic [CW-1:0] res_fill_ff, res_fill_in;
   logic          res_notify_ff, res_notify_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic [6:0]    rsp_fill_ff, rsp_fill_in;
   logic          rsp_notify_ff, rsp_notify_in;

   logic          move;
   logic          produce;
   logic          req_ready;
   logic          accept;
   logic          mem_we;
   logic          notify_on;
   logic [CW-1:0] push_cnt;

   assign move      = res_pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = (state_ff == S_IDLE) && (!res_pend_ff || move);
   assign accept    = req_chan.valid && req_ready;
   assign notify_on = (nmode_ff == NMODE_NOTIFY) || (nmode_ff == NMODE_QUEUE);
   assign push_cnt  = (cnt_ff == CW'(STORE_DEPTH)) ? cnt_ff : CW'(cnt_ff + CW'(1));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      nmode_in      = nmode_ff;
      iss_k_in      = iss_k_ff;
      iss_addr_in   = iss_addr_ff;
      rd_vld_in     = 1'b0;
      rd_k_in       = iss_k_ff;
      rd_addr_in    = iss_addr_ff;
      open_seen_in  = open_seen_ff;
      open_off_in   = open_off_ff;
      cmd_in        = cmd_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_cmd_in    = res_cmd_ff;
      res_data_in   = res_data_ff;
      res_fill_in   = res_fill_ff;
      res_notify_in = res_notify_ff;
      produce       = 1'b0;
      mem_we        = 1'b0;

      if (csr_wr_en) begin
         nmode_in = nmode_type'(csr_wr_data);
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.func == FUNC_PUSH) begin
                  mem_we  = 1'b1;
                  tail_in = ptr_inc(tail_ff);
                  // tail catches head when the store is or becomes full
                  if (cnt_ff >= CW'(STORE_DEPTH - 1)) begin
                     head_in = ptr_inc(head_ff);
                  end
                  cnt_in        = push_cnt;
                  produce       = 1'b1;
                  res_status_in = ST_STORED;
                  res_cmd_in    = '0;
                  res_data_in   = '0;
                  res_fill_in   = push_cnt;
                  res_notify_in = notify_on && (push_cnt >= CW'(NOTIFY_MIN));
               end else if (cnt_ff == '0) begin
                  produce       = 1'b1;
                  res_status_in = ST_EMPTY;
                  res_cmd_in    = '0;
                  res_data_in   = '0;
                  res_fill_in   = '0;
                  res_notify_in = 1'b0;
               end else begin
                  state_in     = S_SCAN;
                  iss_k_in     = '0;
                  iss_addr_in  = head_ff;
                  open_seen_in = 1'b0;
               end
            end
         end

         S_SCAN: begin
            if (iss_k_ff < cnt_ff) begin
               rd_vld_in   = 1'b1;
               iss_k_in    = CW'(iss_k_ff + CW'(1));
               iss_addr_in = ptr_inc(iss_addr_ff);
            end
            if (rd_vld_ff) begin
               prev_in = rd_data_ff;
               if (!open_seen_ff) begin
                  if (rd_data_ff == CH_OPEN) begin
                     open_seen_in = 1'b1;
                     open_off_in  = rd_k_ff;
                  end
               end else begin
                  if (rd_k_ff == CW'(open_off_ff + CW'(1))) begin
                     cmd_in = rd_data_ff;
                  end
               end
               if (open_seen_ff && rd_data_ff == CH_CLOSE) begin
                  state_in      = S_FIN;
                  head_in       = ptr_inc(rd_addr_ff);
                  cnt_in        = '0;
                  res_notify_in = 1'b0;
                  if (rd_k_ff == CW'(open_off_ff + CW'(FRAME_LEN + 1))) begin
                     res_status_in = ST_OK;
                     res_cmd_in    = cmd_ff;
                     res_data_in   = prev_ff;
                  end else begin
                     res_status_in = ST_LEN_ERR;
                     res_cmd_in    = '0;
                     res_data_in   = '0;
                  end
               end else if (rd_k_ff == CW'(cnt_ff - CW'(1))) begin
                  // a marker is missing: drop everything
                  state_in      = S_IDLE;
                  head_in       = '0;
                  tail_in       = '0;
                  cnt_in        = '0;
                  produce       = 1'b1;
                  res_status_in = ST_FMT_ERR;
                  res_cmd_in    = '0;
                  res_data_in   = '0;
                  res_fill_in   = '0;
                  res_notify_in = 1'b0;
               end
            end
         end

         S_FIN: begin
            state_in    = S_IDLE;
            cnt_in      = ptr_dist(tail_ff, head_ff);
            res_fill_in = ptr_dist(tail_ff, head_ff);
            produce     = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      res_pend_in = (res_pend_ff && !move) || produce;

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_notify_in = rsp_notify_ff;
      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_cmd_in    = res_cmd_ff;
         rsp_data_in   = res_data_ff;
         rsp_fill_in   = 7'(res_fill_ff);
         rsp_notify_in = res_notify_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= req_chan.rx_byte;
      end
      rd_data_ff <= mem[iss_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         nmode_ff     <= NMODE_OFF;
         rd_vld_ff    <= 1'b0;
         open_seen_ff <= 1'b0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         nmode_ff     <= nmode_in;
         rd_vld_ff    <= rd_vld_in;
         open_seen_ff <= open_seen_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iss_k_ff      <= iss_k_in;
      iss_addr_ff   <= iss_addr_in;
      rd_k_ff       <= rd_k_in;
      rd_addr_ff    <= rd_addr_in;
      open_off_ff   <= open_off_in;
      cmd_ff        <= cmd_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_cmd_ff    <= res_cmd_in;
      res_data_ff   <= res_data_in;
      res_fill_ff   <= res_fill_in;
      res_notify_ff <= res_notify_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_notify_ff <= rsp_notify_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.frame_cmd  = rsp_cmd_ff;
   assign rsp_chan.frame_data = rsp_data_ff;
   assign rsp_chan.fill_level = rsp_fill_ff;
   assign rsp_chan.notify     = rsp_notify_ff;

   // a new response never lands on one that has not moved out yet
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (produce && res_pend_ff) |-> move)
      else $error("response overwritten in holding register");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   // while full, head sits one past tail
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CW'(STORE_DEPTH)) |-> (head_ff == ptr_inc(tail_ff)))
      else $error("head/tail out of step while full");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff != '0))
      else $error("scan started on empty store");

endmodule

>>> tb/uart_ring_buffer_frame_extractor_tb.sv
`timescale 1ns / 100ps

module uart_ring_buffer_frame_extractor_tb import urbfe_pkg::*; ();

   localparam int DEPTH      = 64;
   localparam int IDLE_PCT   = 13;
   localparam int STALL_MAX  = 3000;
   localparam int DRAIN_WAIT = DEPTH + 16;

   typedef struct {
      status_type  status;
      logic [7:0]  cmd;
      logic [7:0]  data;
      logic [6:0]  fill;
      logic        notify;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   urbfe_req_if req_chan ();
   urbfe_rsp_if rsp_chan ();

   uart_ring_buffer_frame_extractor #(.STORE_DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the ring and its pointers
   logic [7:0] model_store [DEPTH];
   logic [5:0] model_head = '0;
   logic [5:0] model_tail = '0;
   logic       model_full = 1'b0;
   logic [1:0] model_mode = NMODE_OFF;

   frame_result_type pending_results [$];
   int error_count = 0;
   int sent_items  = 0;
   int push_count  = 0;
   int parse_count = 0;
   int full_count  = 0;
   int status_seen [5] = '{default: 0};
   int idle_cycles = 0;
   bit stall_free  = 1'b0;

   function automatic logic [6:0] held_count();
      return model_full ? 7'(DEPTH) : {1'b0, 6'(model_tail - model_head)};
   endfunction

   function automatic logic [7:0] held_byte(int off);
      return model_store[(int'(model_head) + off) % DEPTH];
   endfunction

   function automatic frame_result_type predict_frame_step(func_type f, logic [7:0] b);
      frame_result_type r;
      int n, open_off, close_off;
      bit have_open, have_close;
      r.status = ST_STORED;
      r.cmd    = '0;
      r.data   = '0;
      r.notify = 1'b0;
      if (f == FUNC_PUSH) begin
         model_store[model_tail] = b;
         if (int'(held_count()) == DEPTH - 1) model_full = 1'b1;
         model_tail = model_tail + 6'd1;
         // overrun drops the oldest byte
         if (model_head == model_tail) model_head = model_head + 6'd1;
         r.fill   = held_count();
         r.notify = (model_mode == NMODE_NOTIFY || model_mode == NMODE_QUEUE) &&
                    int'(r.fill) >= NOTIFY_MIN;
      end else begin
         n = int'(held_count());
         if (n == 0) begin
            r.status = ST_EMPTY;
         end else begin
            have_open  = 1'b0;
            have_close = 1'b0;
            open_off   = 0;
            close_off  = 0;
            for (int k = 0; k < n; k++) begin
               if (!have_open && held_byte(k) == CH_OPEN) begin
                  open_off  = k;
                  have_open = 1'b1;
               end
            end
            if (have_open) begin
               for (int k = open_off; k < n; k++) begin
                  if (!have_close && held_byte(k) == CH_CLOSE) begin
                     close_off  = k;
                     have_close = 1'b1;
                  end
               end
            end
            if (have_open && have_close) begin
               if (close_off - open_off - 1 == FRAME_LEN) begin
                  r.status = ST_OK;
                  r.cmd    = held_byte(open_off + 1);
                  r.data   = held_byte(close_off - 1);
               end else begin
                  r.status = ST_LEN_ERR;
               end
               model_head = 6'((int'(model_head) + close_off + 1) % DEPTH);
               model_full = 1'b0;
            end else begin
               r.status   = ST_FMT_ERR;
               model_head = '0;
               model_tail = '0;
               model_full = 1'b0;
            end
         end
         r.fill = held_count();
      end
      return r;
   endfunction

   // request side: predict on every transfer
   always @(posedge clock) begin
      frame_result_type r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = predict_frame_step(req_chan.func, req_chan.rx_byte);
         pending_results.push_back(r);
         status_seen[r.status]++;
         if (req_chan.func == FUNC_PUSH) push_count++;
         else parse_count++;
         if (int'(r.fill) == DEPTH) full_count++;
      end
   end

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing expected, expected none actual status %0d",
                     $time, rsp_chan.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_chan.status));
            check_field("frame_cmd", want.cmd, rsp_chan.frame_cmd);
            check_field("frame_data", want.data, rsp_chan.frame_data);
            check_field("fill_level", 8'(want.fill), 8'(rsp_chan.fill_level));
            check_field("notify", 8'(want.notify), 8'(rsp_chan.notify));
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && (stall_free || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("uart_ring_buffer_frame_extractor_tb: done, errors");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high on return
   task automatic send_item(func_type f, logic [7:0] b);
      while (!stall_free && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= f;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic push_byte(logic [7:0] b);
      send_item(FUNC_PUSH, b);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_notify_mode(logic [1:0] mode);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      model_mode = mode;
   endtask

   task automatic test_empty_parse();
      send_item(FUNC_PARSE, 8'hFF);
   endtask

   // reset mode gives no notify even at fill 3
   task automatic test_good_frame();
      push_byte(CH_OPEN);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_CLOSE);
      send_item(FUNC_PARSE, 8'h00);
   endtask

   // leading junk is skipped, one-byte body is a length error
   task automatic test_length_error();
      push_byte(8'hFF);
      push_byte(CH_OPEN);
      push_byte(8'h00);
      push_byte(CH_CLOSE);
      send_item(FUNC_PARSE, 8'hA5);
   endtask

   // a close marker ahead of the open one does not count
   task automatic test_format_error();
      push_byte(CH_CLOSE);
      push_byte(CH_OPEN);
      send_item(FUNC_PARSE, 8'h5A);
   endtask

   task automatic test_notify_modes();
      write_notify_mode(NMODE_QUEUE);
      push_byte(CH_OPEN);
      push_byte(8'h12);
      write_notify_mode(NMODE_NOTIFY);
      push_byte(8'h34);
      push_byte(CH_CLOSE);
      send_item(FUNC_PARSE, 8'h00);
      write_notify_mode(2'd3);
      push_byte(8'hAA);
      push_byte(8'h55);
      push_byte(8'h80);
      send_item(FUNC_PARSE, 8'h01);
   endtask

   task automatic push_frame(int body_len);
      push_byte(CH_OPEN);
      repeat (body_len) push_byte(8'($urandom_range(255)));
      push_byte(CH_CLOSE);
   endtask

   task automatic test_random_traffic(logic [1:0] mode, int n_items, bit no_stall);
      int stop_at;
      int pick;
      write_notify_mode(mode);
      stall_free = no_stall;
      stop_at    = sent_items + n_items;
      while (sent_items < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)));
            push_frame(FRAME_LEN);
            if ($urandom_range(99) < 70) send_item(FUNC_PARSE, 8'($urandom_range(255)));
         end else if (pick < 75) begin
            push_frame($urandom_range(4));
            send_item(FUNC_PARSE, 8'($urandom_range(255)));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
         end else if (pick < 95) begin
            send_item(FUNC_PARSE, 8'($urandom_range(255)));
         end else if (pick < 98) begin
            // 60 to 80 bytes of frames: near the ring's depth, often enough to fill and overrun it
            repeat ($urandom_range(15, 20)) push_frame(FRAME_LEN);
         end else begin
            repeat ($urandom_range(60, 80)) push_byte(8'($urandom_range(255)));
         end
      end
      stall_free = 1'b0;
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_PUSH;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_parse();
      test_good_frame();
      test_length_error();
      test_format_error();
      test_notify_modes();
      test_random_traffic(NMODE_NOTIFY, 400, 1'b0);
      test_random_traffic(2'd3, 400, 1'b0);
      test_random_traffic(NMODE_QUEUE, 400, 1'b1);
      test_random_traffic(NMODE_OFF, 400, 1'b0);

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("covered %0d pushes and %0d parses over notify modes 0 to 3, %0d at full store",
               push_count, parse_count, full_count);
      $display("parse outcomes: %0d frames, %0d empty, %0d length errors, %0d format errors",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_LEN_ERR],
               status_seen[ST_FMT_ERR]);
      if (error_count == 0)
         $display("uart_ring_buffer_frame_extractor_tb: done, clean");
      else
         $display("uart_ring_buffer_frame_extractor_tb: done, errors");
      $finish;
   end

endmodule
